[design/mexp_pkg.sv]
// ----------------------------------------------------------------------------
// mexp_pkg: shared constants for the modular exponentiation block
// Field widths of the channels and the default operand width.
// ----------------------------------------------------------------------------
package mexp_pkg;

  // width of every payload field and of the modulus register
  localparam int unsigned FIELD_W = 63;

  // default number of low operand bits used by the datapath
  localparam int unsigned OPERAND_BITS_DEF = 63;

endpackage

[design/mexp_ifs.sv]
// ----------------------------------------------------------------------------
// mexp channel interfaces
// Valid/ready channels for the operand words and the result words.
// ----------------------------------------------------------------------------
interface mexp_in_if
  import mexp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] base;
  logic [FIELD_W-1:0] exponent;

  modport source(output valid, output base, output exponent, input ready);
  modport sink(input valid, input base, input exponent, output ready);
endinterface

interface mexp_out_if
  import mexp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] power;

  modport source(output valid, output power, input ready);
  modport sink(input valid, input power, output ready);
endinterface

[design/modular_exponentiation_double_add_top.sv]
// ----------------------------------------------------------------------------
// modular_exponentiation_double_add_top: base^exponent mod modulus
// Right-to-left square-and-multiply over double-and-add modular products.
// ----------------------------------------------------------------------------
// One operand word at a time. The base is first reduced by restoring
// division, one bit per cycle. Then every exponent bit, scanned from the
// LSB, costs a decision step in ST_NEXT, a squaring and, when the bit is set,
// a multiplication; each product runs one multiplier bit per cycle and stops
// once the remaining multiplier bits are zero. The final squaring is skipped.
// The input is not ready from the accepted word until its result is taken.
// An exponent of zero gives 1; a modulus of zero acts as a modulus of one.
// ----------------------------------------------------------------------------
module modular_exponentiation_double_add_top
  import mexp_pkg::*;
#(
  parameter int unsigned OPERAND_BITS = OPERAND_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [FIELD_W-1:0] cfg_wdata,
  mexp_in_if.sink            in_if,
  mexp_out_if.source         out_if
);

  localparam int unsigned W  = OPERAND_BITS;
  localparam int unsigned CW = $clog2(W);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_REDUCE = 6'b000010,
    ST_NEXT   = 6'b000100,
    ST_MUL    = 6'b001000,
    ST_SQR    = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [FIELD_W-1:0] modulus_r;
  logic [W-1:0]       m_r, m_nxt;
  logic [W-1:0]       e_r, e_nxt;
  logic [W-1:0]       b_r, b_nxt;
  logic [W-1:0]       acc_r, acc_nxt;
  logic [W-1:0]       pacc_r, pacc_nxt;
  logic [W-1:0]       d_r, d_nxt;
  logic [W-1:0]       y_r, y_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;

  logic [W-1:0] mod_in;

  // shared add-and-reduce datapath: port A adds, port B doubles
  logic [W-1:0] ua_x, ua_y;
  logic         ua_cin;
  logic [W:0]   ua_sum, ub_sum;
  logic [W-1:0] ua_res, ub_res;

  always_comb begin
    ua_sum = {1'b0, ua_x} + {1'b0, ua_y} + (W+1)'(ua_cin);
    if (ua_sum >= {1'b0, m_r}) begin
      ua_res = W'(ua_sum - {1'b0, m_r});
    end else begin
      ua_res = ua_sum[W-1:0];
    end
    ub_sum = {1'b0, d_r} + {1'b0, d_r};
    if (ub_sum >= {1'b0, m_r}) begin
      ub_res = W'(ub_sum - {1'b0, m_r});
    end else begin
      ub_res = ub_sum[W-1:0];
    end
  end

  assign mod_in = (modulus_r[W-1:0] == '0) ? W'(1) : modulus_r[W-1:0];

  always_comb begin
    ua_x = pacc_r;
    ua_y = d_r;
    ua_cin = 1'b0;
    if (state_r == ST_REDUCE) begin
      ua_y   = pacc_r;
      ua_cin = y_r[W-1];
    end
  end

  always_comb begin
    state_nxt = state_r;
    m_nxt     = m_r;
    e_nxt     = e_r;
    b_nxt     = b_r;
    acc_nxt   = acc_r;
    pacc_nxt  = pacc_r;
    d_nxt     = d_r;
    y_nxt     = y_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          m_nxt     = mod_in;
          e_nxt     = in_if.exponent[W-1:0];
          y_nxt     = in_if.base[W-1:0];
          acc_nxt   = W'(1);
          pacc_nxt  = '0;
          cnt_nxt   = CW'(W - 1);
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        // shift in one base bit, keep the remainder below the modulus
        pacc_nxt = ua_res;
        y_nxt    = y_r << 1;
        cnt_nxt  = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          b_nxt     = ua_res;
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        pacc_nxt = '0;
        y_nxt    = b_r;
        if (e_r == '0) begin
          state_nxt = ST_DONE;
        end else if (e_r[0]) begin
          d_nxt     = acc_r;
          state_nxt = ST_MUL;
        end else begin
          d_nxt     = b_r;
          state_nxt = ST_SQR;
        end
      end
      ST_MUL, ST_SQR: begin
        if (y_r == '0) begin
          if (state_r == ST_MUL) begin
            acc_nxt = pacc_r;
            // drop the consumed bit; the square follows from ST_NEXT unless no bits remain
            e_nxt   = {e_r[W-1:1], 1'b0};
          end else begin
            b_nxt = pacc_r;
            e_nxt = e_r >> 1;
          end
          state_nxt = ST_NEXT;
        end else begin
          if (y_r[0]) begin
            pacc_nxt = ua_res;
          end
          d_nxt = ub_res;
          y_nxt = y_r >> 1;
        end
      end
      ST_DONE: begin
        if (out_if.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      modulus_r <= FIELD_W'(1);
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        modulus_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    m_r    <= m_nxt;
    e_r    <= e_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    pacc_r <= pacc_nxt;
    d_r    <= d_nxt;
    y_r    <= y_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign in_if.ready  = (state_r == ST_IDLE);
  assign out_if.valid = (state_r == ST_DONE);
  assign out_if.power = FIELD_W'(acc_r);

endmodule
